[rtl/core/swfr_pkg.sv]
package swfr_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 4;

  // register indexes of the configuration port
  localparam logic [CfgIndexWidth-1:0] CFG_STATION_ADDRESS = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_STRICT_SEQUENCE = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_ODD_PARITY      = 2'd2;

  localparam logic [1:0] STATUS_GOOD   = 2'd0;
  localparam logic [1:0] STATUS_SEQ    = 2'd1;
  localparam logic [1:0] STATUS_PARITY = 2'd2;

  localparam logic [15:0] TALLY_MAX = 16'hFFFF;

  typedef struct packed {
    logic [3:0] station_address;
    logic       strict_sequence;
    logic       odd_parity;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload;
    logic [1:0]  frame_status;
    logic [2:0]  sequence_seen;
    logic [15:0] good_frames;
    logic [15:0] bad_frames;
  } result_t;

endpackage

[rtl/core/swfr_parser.sv]
module swfr_parser #(
  parameter int unsigned PreambleBits = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swfr_pkg::cfg_t    cfg_i,
  input  logic              bit_valid_i,
  input  logic              bit_i,
  output logic              res_valid_o,
  output swfr_pkg::result_t res_o
);

  localparam int unsigned IdxW = ($clog2(PreambleBits) > 3) ? $clog2(PreambleBits) : 3;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_ADDR   = 3'd1;
  localparam logic [2:0] PH_SEQ    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_PARITY = 3'd4;

  logic [2:0]      phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      shift_q, shift_d;
  logic [2:0]      seq_q, seq_d;
  logic            par_q, par_d;
  logic [2:0]      last_q, last_d;
  logic [15:0]     good_q, good_d;
  logic [15:0]     bad_q, bad_d;

  logic [3:0] addr_new;
  logic [2:0] seq_new;
  logic       par_new;
  logic       want;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    seq_d   = seq_q;
    par_d   = par_q;
    last_d  = last_q;
    good_d  = good_q;
    bad_d   = bad_q;

    res_valid_o         = 1'b0;
    res_o.payload       = '0;
    res_o.frame_status  = swfr_pkg::STATUS_GOOD;
    res_o.sequence_seen = seq_q;
    res_o.good_frames   = good_q;
    res_o.bad_frames    = bad_q;

    par_new  = par_q ^ bit_i;
    want     = ~idx_q[0];
    addr_new = shift_q[3:0] | (4'(bit_i) << idx_q[1:0]);
    seq_new  = seq_q | (3'(bit_i) << idx_q[1:0]);

    if (bit_valid_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (bit_i == want) begin
            par_d = ((idx_q == '0) ? 1'b0 : par_q) ^ bit_i;
            if (idx_q == IdxW'(PreambleBits - 1)) begin
              phase_d = PH_ADDR;
              idx_d   = '0;
              shift_d = '0;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end else if (bit_i) begin
            // a stray 1 may be the first bit of a new preamble
            idx_d = IdxW'(1);
            par_d = 1'b1;
          end else begin
            idx_d = '0;
            par_d = 1'b0;
          end
        end
        PH_ADDR: begin
          par_d   = par_new;
          shift_d = {shift_q[7:4], addr_new};
          if (idx_q == IdxW'(3)) begin
            if (addr_new == cfg_i.station_address) begin
              phase_d = PH_SEQ;
              idx_d   = '0;
              seq_d   = '0;
            end else begin
              last_d  = 3'd7;
              phase_d = PH_HUNT;
              idx_d   = '0;
              shift_d = '0;
              seq_d   = '0;
              par_d   = 1'b0;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        PH_SEQ: begin
          par_d = par_new;
          seq_d = seq_new;
          if (idx_q == IdxW'(2)) begin
            idx_d = '0;
            if (cfg_i.strict_sequence && (seq_new != last_q + 3'd1)) begin
              last_d              = 3'd7;
              res_valid_o         = 1'b1;
              res_o.frame_status  = swfr_pkg::STATUS_SEQ;
              res_o.sequence_seen = seq_new;
              phase_d = PH_HUNT;
              shift_d = '0;
              seq_d   = '0;
              par_d   = 1'b0;
            end else begin
              if (cfg_i.strict_sequence) begin
                last_d = seq_new;
              end
              phase_d = PH_DATA;
              shift_d = '0;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        PH_DATA: begin
          par_d   = par_new;
          shift_d = {shift_q[6:0], bit_i};
          if (idx_q == IdxW'(7)) begin
            phase_d = PH_PARITY;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: begin
          res_valid_o = 1'b1;
          if (par_new == cfg_i.odd_parity) begin
            if (good_q != swfr_pkg::TALLY_MAX) begin
              good_d = good_q + 16'd1;
            end
            res_o.payload = shift_q;
          end else begin
            if (bad_q != swfr_pkg::TALLY_MAX) begin
              bad_d = bad_q + 16'd1;
            end
            res_o.frame_status = swfr_pkg::STATUS_PARITY;
          end
          res_o.good_frames = good_d;
          res_o.bad_frames  = bad_d;
          phase_d = PH_HUNT;
          idx_d   = '0;
          shift_d = '0;
          seq_d   = '0;
          par_d   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= '0;
      shift_q <= '0;
      seq_q   <= '0;
      par_q   <= 1'b0;
      last_q  <= 3'd7;
      good_q  <= '0;
      bad_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      seq_q   <= seq_d;
      par_q   <= par_d;
      last_q  <= last_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
    end
  end

endmodule

[rtl/core/single_wire_frame_receiver_top.sv]
// Single-wire frame receiver: takes one line bit per request and assembles frames of an
// alternating preamble (PREAMBLE_BITS bits, starting with 1), a 4-bit address and 3-bit
// sequence number sent LSB first, 8 data bits MSB first and a parity bit over the whole
// frame. Each frame for this station gives one result (good, sequence error or parity
// error) with saturating good and bad frame counts; frames for other addresses give none.
// A bit is taken every cycle unless stalled: the frame state updates in the cycle the bit
// is accepted and the result is registered in the output register, or the skid register
// if the output stalls. The two-entry stage lets bits keep flowing while a result waits;
// the input stalls only when both entries are full. Configuration writes are always ready.
module single_wire_frame_receiver_top #(
  parameter int unsigned PREAMBLE_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [swfr_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [swfr_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               line_bit_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         payload_o,
  output logic [1:0]                         frame_status_o,
  output logic [2:0]                         sequence_seen_o,
  output logic [15:0]                        good_frames_o,
  output logic [15:0]                        bad_frames_o
);

  swfr_pkg::cfg_t    cfg_q;
  swfr_pkg::result_t res;
  swfr_pkg::result_t out_q, skid_q;
  logic              res_valid;
  logic              out_valid_q, skid_valid_q;
  logic              in_accept;
  logic              out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        swfr_pkg::CFG_STATION_ADDRESS: cfg_q.station_address <= cfg_data_i[3:0];
        swfr_pkg::CFG_STRICT_SEQUENCE: cfg_q.strict_sequence <= cfg_data_i[0];
        swfr_pkg::CFG_ODD_PARITY:      cfg_q.odd_parity      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  swfr_parser #(
    .PreambleBits(PREAMBLE_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .bit_valid_i(in_accept),
    .bit_i      (line_bit_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_o       = out_q.payload;
  assign frame_status_o  = out_q.frame_status;
  assign sequence_seen_o = out_q.sequence_seen;
  assign good_frames_o   = out_q.good_frames;
  assign bad_frames_o    = out_q.bad_frames;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_result_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !out_free |=> skid_valid_q && out_valid_q)
    else $error("result produced while stalled was lost");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_status_o == swfr_pkg::STATUS_GOOD ||
                     frame_status_o == swfr_pkg::STATUS_SEQ ||
                     frame_status_o == swfr_pkg::STATUS_PARITY))
    else $error("undefined frame status");

  a_good_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o == swfr_pkg::STATUS_GOOD |-> good_frames_o != 16'd0)
    else $error("good frame without good count");

  a_bad_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o == swfr_pkg::STATUS_PARITY |-> bad_frames_o != 16'd0)
    else $error("parity error without bad count");
`endif

endmodule

[tb/testbench.sv]
module testbench;

  localparam int unsigned PreambleBits = 12;
  localparam int unsigned FrameBits    = PreambleBits + 16;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned MaxReports   = 30;
  localparam int unsigned RandomBits   = 180;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_SEQ,
    PH_DATA,
    PH_PARITY
  } rx_phase_e;

  logic                               clk_i;
  logic                               rst_ni      = 1'b0;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [swfr_pkg::CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [swfr_pkg::CfgDataWidth-1:0]  cfg_data_i  = '0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_stall_o;
  logic                               line_bit_i  = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic [7:0]                         payload_o;
  logic [1:0]                         frame_status_o;
  logic [2:0]                         sequence_seen_o;
  logic [15:0]                        good_frames_o;
  logic [15:0]                        bad_frames_o;

  single_wire_frame_receiver_top #(
    .PREAMBLE_BITS(PreambleBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .line_bit_i     (line_bit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_o      (payload_o),
    .frame_status_o (frame_status_o),
    .sequence_seen_o(sequence_seen_o),
    .good_frames_o  (good_frames_o),
    .bad_frames_o   (bad_frames_o)
  );

  // receiver shadow state
  swfr_pkg::cfg_t    shadow_cfg;
  rx_phase_e         rx_phase;
  int unsigned       rx_idx;
  logic [7:0]        rx_shift;
  logic [2:0]        rx_seq;
  logic              rx_par;
  logic [2:0]        last_seq;
  logic [15:0]       good_cnt;
  logic [15:0]       bad_cnt;
  swfr_pkg::result_t expected_frames[$];

  int unsigned cycle_count  = 0;
  int unsigned mismatches   = 0;
  int unsigned bits_sent    = 0;
  int unsigned frames_seen  = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_good       = 0;
  int unsigned n_seq_err    = 0;
  int unsigned n_par_err    = 0;
  int unsigned hold_request = 0;
  bit          tx_gaps      = 1'b1;
  bit          rx_gaps      = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void restart_hunt();
    rx_phase = PH_HUNT;
    rx_idx   = 0;
    rx_shift = '0;
    rx_seq   = '0;
    rx_par   = 1'b0;
  endfunction

  function automatic void queue_result(input logic [7:0] data, input logic [1:0] status);
    swfr_pkg::result_t r;
    r.payload       = data;
    r.frame_status  = status;
    r.sequence_seen = rx_seq;
    r.good_frames   = good_cnt;
    r.bad_frames    = bad_cnt;
    expected_frames.push_back(r);
    case (status)
      swfr_pkg::STATUS_GOOD: n_good++;
      swfr_pkg::STATUS_SEQ:  n_seq_err++;
      default:               n_par_err++;
    endcase
  endfunction

  // advance the shadow receiver by one accepted line bit
  function automatic void track_bit(input logic b);
    case (rx_phase)
      PH_HUNT: begin
        if (b == ~rx_idx[0]) begin
          rx_par = ((rx_idx == 0) ? 1'b0 : rx_par) ^ b;
          rx_idx++;
          if (rx_idx >= PreambleBits) begin
            rx_phase = PH_ADDR;
            rx_idx   = 0;
            rx_shift = '0;
          end
        end else if (b) begin
          // slipped bit is taken as preamble bit one
          rx_idx = 1;
          rx_par = 1'b1;
        end else begin
          rx_idx = 0;
          rx_par = 1'b0;
        end
      end
      PH_ADDR: begin
        rx_par ^= b;
        rx_shift[rx_idx] = b;
        if (rx_idx >= 3) begin
          if (rx_shift[3:0] == shadow_cfg.station_address) begin
            rx_phase = PH_SEQ;
            rx_idx   = 0;
            rx_seq   = '0;
          end else begin
            last_seq = 3'd7;
            restart_hunt();
          end
        end else begin
          rx_idx++;
        end
      end
      PH_SEQ: begin
        rx_par ^= b;
        rx_seq[rx_idx] = b;
        if (rx_idx >= 2) begin
          rx_idx = 0;
          if (shadow_cfg.strict_sequence) begin
            if (rx_seq == last_seq + 3'd1) begin
              last_seq = rx_seq;
            end else begin
              last_seq = 3'd7;
              queue_result(8'h00, swfr_pkg::STATUS_SEQ);
              restart_hunt();
              return;
            end
          end
          rx_phase = PH_DATA;
          rx_shift = '0;
        end else begin
          rx_idx++;
        end
      end
      PH_DATA: begin
        rx_par ^= b;
        rx_shift = {rx_shift[6:0], b};
        if (rx_idx >= 7) begin
          rx_phase = PH_PARITY;
          rx_idx   = 0;
        end else begin
          rx_idx++;
        end
      end
      default: begin
        rx_par ^= b;
        if (rx_par == shadow_cfg.odd_parity) begin
          if (good_cnt != swfr_pkg::TALLY_MAX) good_cnt++;
          queue_result(rx_shift, swfr_pkg::STATUS_GOOD);
        end else begin
          if (bad_cnt != swfr_pkg::TALLY_MAX) bad_cnt++;
          queue_result(8'h00, swfr_pkg::STATUS_PARITY);
        end
        restart_hunt();
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    if (mismatches < MaxReports)
      $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    swfr_pkg::result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) stall_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result with nothing pending, status", 16'h0,
                          16'(frame_status_o));
        end else begin
          want = expected_frames.pop_front();
          frames_seen++;
          if (payload_o !== want.payload)
            report_mismatch("payload", 16'(want.payload), 16'(payload_o));
          if (frame_status_o !== want.frame_status)
            report_mismatch("frame_status", 16'(want.frame_status), 16'(frame_status_o));
          if (sequence_seen_o !== want.sequence_seen)
            report_mismatch("sequence_seen", 16'(want.sequence_seen),
                            16'(sequence_seen_o));
          if (good_frames_o !== want.good_frames)
            report_mismatch("good_frames", want.good_frames, good_frames_o);
          if (bad_frames_o !== want.bad_frames)
            report_mismatch("bad_frames", want.bad_frames, bad_frames_o);
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count++;

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             expected_frames.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // output side: random stall bursts, plus a long hold-off on request
  initial begin : out_stall_gen
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // one line bit request, predicted once accepted
  task automatic send_bit(input logic b);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    line_bit_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    track_bit(b);
    bits_sent++;
  endtask

  // zeros until the hunt is back at its start
  task automatic resync();
    while (rx_phase != PH_HUNT || rx_idx != 0) send_bit(1'b0);
  endtask

  // sends frame bits first..last-1, parity bit made good or bad for the current mode
  task automatic send_frame(input logic [3:0] addr, input logic [2:0] seq,
                            input logic [7:0] data, input bit parity_ok,
                            input int first, input int last);
    logic bits[$];
    logic p;
    p = 1'b0;
    for (int i = 0; i < PreambleBits; i++) bits.push_back((i % 2) == 0);
    for (int i = 0; i < 4; i++) bits.push_back(addr[i]);
    for (int i = 0; i < 3; i++) bits.push_back(seq[i]);
    for (int i = 7; i >= 0; i--) bits.push_back(data[i]);
    foreach (bits[i]) p ^= bits[i];
    bits.push_back(p ^ shadow_cfg.odd_parity ^ !parity_ok);
    for (int i = first; i < last; i++) send_bit(bits[i]);
    resync();
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [swfr_pkg::CfgIndexWidth-1:0] idx,
                           input logic [swfr_pkg::CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      swfr_pkg::CFG_STATION_ADDRESS: shadow_cfg.station_address = data;
      swfr_pkg::CFG_STRICT_SEQUENCE: shadow_cfg.strict_sequence = data[0];
      swfr_pkg::CFG_ODD_PARITY:      shadow_cfg.odd_parity = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [3:0] addr, input logic strict, input logic odd);
    wait_results();
    cfg_write(swfr_pkg::CFG_STATION_ADDRESS, addr);
    cfg_write(swfr_pkg::CFG_STRICT_SEQUENCE, {3'b000, strict});
    cfg_write(swfr_pkg::CFG_ODD_PARITY, {3'b000, odd});
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed frames, some cut short, some line noise
  task automatic random_slot();
    int unsigned kind;
    logic [3:0]  addr;
    logic [2:0]  seq;
    kind = $urandom_range(0, 99);
    addr = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                       : shadow_cfg.station_address;
    seq = (shadow_cfg.strict_sequence && $urandom_range(0, 7) != 0) ? last_seq + 3'd1
                                                                    : 3'($urandom_range(0, 7));
    if (kind < 75) begin
      send_frame(addr, seq, 8'($urandom_range(0, 255)), $urandom_range(0, 6) != 0,
                 0, FrameBits);
    end else if (kind < 88) begin
      send_frame(addr, seq, 8'($urandom_range(0, 255)), 1'b1, 0,
                 $urandom_range(1, FrameBits - 1));
    end else begin
      repeat ($urandom_range(1, 12)) send_bit(1'($urandom_range(0, 1)));
      resync();
    end
  endtask

  task automatic test_directed_frames();
    configure(4'd0, 1'b0, 1'b0);
    send_frame(4'd0, 3'd0, 8'h00, 1'b1, 0, FrameBits);
    send_frame(4'd0, 3'd7, 8'hFF, 1'b1, 0, FrameBits);
    send_frame(4'd0, 3'd2, 8'hA5, 1'b0, 0, FrameBits);
    // a mismatching one restarts the hunt at position one
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);
    send_frame(4'd0, 3'd5, 8'h3C, 1'b1, 1, FrameBits);
    // a mismatching zero restarts the hunt from scratch
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b0);
    send_frame(4'd0, 3'd1, 8'h81, 1'b1, 0, FrameBits);
    send_frame(4'd5, 3'd0, 8'h55, 1'b1, 0, FrameBits);
    configure(4'd15, 1'b1, 1'b1);
    send_frame(4'd15, 3'd0, 8'h12, 1'b1, 0, FrameBits);
    send_frame(4'd15, 3'd1, 8'h34, 1'b1, 0, FrameBits);
    send_frame(4'd15, 3'd3, 8'h56, 1'b1, 0, FrameBits);
    send_frame(4'd15, 3'd0, 8'h78, 1'b1, 0, FrameBits);
    send_frame(4'd15, 3'd1, 8'h9A, 1'b0, 0, FrameBits);
    send_frame(4'd14, 3'd2, 8'hBC, 1'b1, 0, FrameBits);
    send_frame(4'd15, 3'd0, 8'hDE, 1'b1, 0, FrameBits);
    configure(4'd15, 1'b0, 1'b1);
    send_frame(4'd15, 3'd6, 8'hF0, 1'b1, 0, FrameBits);
    send_frame(4'd15, 3'd6, 8'h0F, 1'b0, 0, FrameBits);
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       configure(4'd0, 1'b0, 1'b0);
        1:       configure(4'd15, 1'b1, 1'b1);
        default: configure(4'($urandom_range(1, 14)), ph[0], ph[1]);
      endcase
      stop_at = bits_sent + RandomBits / 6;
      while (bits_sent < stop_at) random_slot();
    end
  endtask

  task automatic test_output_holdoff();
    configure(4'd9, 1'b0, 1'b0);
    tx_gaps = 1'b0;
    hold_request = 250;
    repeat (10)
      send_frame(4'd9, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b1,
                 0, FrameBits);
    tx_gaps = 1'b1;
    // sender waits for the backlog to clear
    wait_results();
    repeat (6) random_slot();
  endtask

  task automatic test_steady_stream();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    configure(4'($urandom_range(0, 15)), 1'b1, 1'($urandom_range(0, 1)));
    repeat (10) random_slot();
  endtask

  initial begin : main
    shadow_cfg = '0;
    restart_hunt();
    last_seq = 3'd7;
    good_cnt = '0;
    bad_cnt  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_random_frames();
    test_output_holdoff();
    test_steady_stream();
    wait_results();
    $display("sent %0d line bits over %0d cycles, input held off %0d cycles",
             bits_sent, cycle_count, stall_cycles);
    $display("checked %0d results: %0d good, %0d sequence errors, %0d parity errors",
             frames_seen, n_good, n_seq_err, n_par_err);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
